>>> design/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types and constants for the RGB Sobel edge magnitude core.
// ----------------------------------------------------------------------------
`default_nettype none

package sobel_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW      = $clog2(MaxWidth);

  typedef logic [ColW-1:0] col_t;
  typedef logic [10:0]     dim_t;
  typedef logic [20:0]     item_t;
  typedef logic [21:0]     sq_t;

  localparam logic [7:0] MagMax   = 8'd255;
  localparam sq_t        SatLimit = 22'd65280;

  // configuration register indexes
  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_pixel;
  } out_t;

  // masked 3x3 neighbourhood, px[row][col], top-left first
  typedef struct packed {
    logic [2:0][2:0][23:0] px;
    logic                  last;
  } win_t;

  typedef enum logic {
    F_IDLE,
    F_READ
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQUARE,
    B_ROOT,
    B_ROUND,
    B_OUT
  } back_state_e;

endpackage

`default_nettype wire

>>> design/sobel_front.sv
// ----------------------------------------------------------------------------
// sobel_front
// Line stores, window and raster counters; pushes masked windows to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire sobel_pkg::dim_t  cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire sobel_pkg::in_t   in_data_i,
  output logic                  push_o,
  output sobel_pkg::win_t       win_o,
  input  wire logic             full_i
);

  sobel_pkg::front_state_e state_q, state_d;

  sobel_pkg::dim_t  width_q, height_q, wc, hc;
  sobel_pkg::item_t items_q, limit;
  sobel_pkg::col_t  col_in_q, c0_q;
  sobel_pkg::dim_t  r0_q;
  logic [23:0]      pix_q, rd_up_q, rd_mid_q;
  logic [2:0][2:0][23:0] win_q, win_nxt;
  logic [23:0]      upper_mem  [0:sobel_pkg::MaxWidth-1];
  logic [23:0]      middle_mem [0:sobel_pkg::MaxWidth-1];

  logic accept, emit, done;
  logic row_ok [3];
  logic col_ok [3];

  assign accept = (state_q == sobel_pkg::F_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != sobel_pkg::F_IDLE);

  always_comb begin
    if (width_q == '0) wc = 11'd1;
    else if (width_q > 11'(sobel_pkg::MaxWidth)) wc = 11'(sobel_pkg::MaxWidth);
    else wc = width_q;
    if (height_q == '0) hc = 11'd1;
    else if (height_q > 11'(sobel_pkg::MaxHeight)) hc = 11'(sobel_pkg::MaxHeight);
    else hc = height_q;
  end

  assign limit = sobel_pkg::item_t'(wc) * sobel_pkg::item_t'(hc) + sobel_pkg::item_t'(wc);
  assign emit  = items_q >= sobel_pkg::item_t'(wc) + 21'd1;
  assign done  = (state_q == sobel_pkg::F_READ) && (!emit || !full_i);
  assign push_o = (state_q == sobel_pkg::F_READ) && emit && !full_i;

  always_comb begin
    // newest column sits at index 0
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][2] = win_q[r][1];
      win_nxt[r][1] = win_q[r][0];
    end
    win_nxt[0][0] = rd_up_q;
    win_nxt[1][0] = rd_mid_q;
    win_nxt[2][0] = pix_q;

    row_ok[0] = (r0_q != '0);
    row_ok[1] = 1'b1;
    row_ok[2] = (r0_q != hc - 11'd1);
    col_ok[0] = (c0_q != '0);
    col_ok[1] = 1'b1;
    col_ok[2] = (11'(c0_q) != wc - 11'd1);

    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win_o.px[r][c] = (row_ok[r] && col_ok[c]) ? win_nxt[r][2-c] : 24'd0;
      end
    end
    win_o.last = (r0_q == hc - 11'd1) && (11'(c0_q) == wc - 11'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sobel_pkg::F_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sobel_pkg::F_IDLE: if (accept) state_d = sobel_pkg::F_READ;
      sobel_pkg::F_READ: if (done) state_d = sobel_pkg::F_IDLE;
      default:           state_d = sobel_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 11'd480;
      items_q  <= '0;
      col_in_q <= '0;
      c0_q     <= '0;
      r0_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sobel_pkg::CfgWidth:  width_q  <= cfg_data_i;
        sobel_pkg::CfgHeight: height_q <= cfg_data_i;
        default: ;
      endcase
      items_q  <= '0;
      col_in_q <= '0;
      c0_q     <= '0;
      r0_q     <= '0;
    end else if (done) begin
      if (items_q == limit) begin
        items_q  <= '0;
        col_in_q <= '0;
        c0_q     <= '0;
        r0_q     <= '0;
      end else begin
        items_q <= items_q + 21'd1;
        if (11'(col_in_q) + 11'd1 == wc) col_in_q <= '0;
        else col_in_q <= col_in_q + 1'b1;
        if (emit) begin
          if (11'(c0_q) + 11'd1 == wc) begin
            c0_q <= '0;
            r0_q <= r0_q + 11'd1;
          end else begin
            c0_q <= c0_q + 1'b1;
          end
        end
      end
    end
  end

  // flush items enter as a zero pixel
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q    <= in_data_i.op ? 24'd0
                  : {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
      rd_up_q  <= upper_mem[col_in_q];
      rd_mid_q <= middle_mem[col_in_q];
    end
    if (done) begin
      upper_mem[col_in_q]  <= rd_mid_q;
      middle_mem[col_in_q] <= pix_q;
      win_q <= win_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/sobel_fifo.sv
// ----------------------------------------------------------------------------
// sobel_fifo
// Two-entry queue of windows between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sobel_pkg::win_t  data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output sobel_pkg::win_t       data_o
);

  sobel_pkg::win_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

endmodule

`default_nettype wire

>>> design/sobel_back.sv
// ----------------------------------------------------------------------------
// sobel_back
// Gradients, squares and a bit-serial rounded square root per channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  wire sobel_pkg::win_t  win_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output sobel_pkg::out_t       out_data_o
);

  sobel_pkg::back_state_e state_q, state_d;

  logic signed [11:0] gx_d [3];
  logic signed [11:0] gy_d [3];
  logic signed [11:0] gx_q [3];
  logic signed [11:0] gy_q [3];
  sobel_pkg::sq_t     s_q  [3];
  logic [7:0]         r_q  [3];
  logic [7:0]         res_d [3];
  logic [2:0]         bit_q;
  logic               last_q;
  sobel_pkg::out_t    out_q;
  logic [2:0][2:0][7:0] p [3];

  assign pop_o       = (state_q == sobel_pkg::B_IDLE) && !empty_i;
  assign out_valid_o = (state_q == sobel_pkg::B_OUT);
  assign out_data_o  = out_q;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p[ch][r][c] = win_i.px[r][c][23-8*ch -: 8];
        end
      end
      gx_d[ch] = (12'(p[ch][0][2]) + (12'(p[ch][1][2]) << 1) + 12'(p[ch][2][2]))
               - (12'(p[ch][0][0]) + (12'(p[ch][1][0]) << 1) + 12'(p[ch][2][0]));
      gy_d[ch] = (12'(p[ch][2][0]) + (12'(p[ch][2][1]) << 1) + 12'(p[ch][2][2]))
               - (12'(p[ch][0][0]) + (12'(p[ch][0][1]) << 1) + 12'(p[ch][0][2]));
    end
  end

  // round to nearest: step up when s lies above r*r + r; saturate to MagMax above SatLimit
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (s_q[ch] > sobel_pkg::SatLimit) res_d[ch] = sobel_pkg::MagMax;
      else if (s_q[ch] > 22'(16'(r_q[ch]) * 16'(r_q[ch])) + 22'(r_q[ch]))
        res_d[ch] = r_q[ch] + 8'd1;
      else res_d[ch] = r_q[ch];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sobel_pkg::B_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sobel_pkg::B_IDLE:   if (!empty_i) state_d = sobel_pkg::B_SQUARE;
      sobel_pkg::B_SQUARE: state_d = sobel_pkg::B_ROOT;
      sobel_pkg::B_ROOT:   if (bit_q == '0) state_d = sobel_pkg::B_ROUND;
      sobel_pkg::B_ROUND:  state_d = sobel_pkg::B_OUT;
      sobel_pkg::B_OUT:    if (!out_stall_i) state_d = sobel_pkg::B_IDLE;
      default:             state_d = sobel_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      sobel_pkg::B_IDLE: begin
        for (int ch = 0; ch < 3; ch++) begin
          gx_q[ch] <= gx_d[ch];
          gy_q[ch] <= gy_d[ch];
        end
        last_q <= win_i.last;
      end
      sobel_pkg::B_SQUARE: begin
        for (int ch = 0; ch < 3; ch++) begin
          s_q[ch] <= 22'(gx_q[ch] * gx_q[ch]) + 22'(gy_q[ch] * gy_q[ch]);
          r_q[ch] <= '0;
        end
        bit_q <= 3'd7;
      end
      sobel_pkg::B_ROOT: begin
        // one result bit per cycle, msb first
        for (int ch = 0; ch < 3; ch++) begin
          if (22'(16'(r_q[ch] | (8'd1 << bit_q)) * 16'(r_q[ch] | (8'd1 << bit_q)))
              <= s_q[ch])
            r_q[ch] <= r_q[ch] | (8'd1 << bit_q);
        end
        bit_q <= bit_q - 3'd1;
      end
      sobel_pkg::B_ROUND: begin
        out_q.red_out    <= res_d[0];
        out_q.green_out  <= res_d[1];
        out_q.blue_out   <= res_d[2];
        out_q.last_pixel <= last_q;
      end
      sobel_pkg::B_OUT: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> design/sobel_edge_magnitude_rgb_core.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_core
// Streaming 3x3 Sobel gradient magnitude on RGB pixels in raster order.
// ----------------------------------------------------------------------------
// In the front each input item has a line store read, then a window
// update, which waits while the queue is full; every item from
// frame_width + 1 onward yields a result. The back computes it in its
// square, root (a bit-serial square root, eight steps), round and output
// states, and takes a new window from the two-entry queue only when idle.
// After the frame, frame_width + 1 flush items drain the remaining
// results. The line stores need no clearing after reset.
`default_nettype none

module sobel_edge_magnitude_rgb_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire sobel_pkg::dim_t  cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire sobel_pkg::in_t   in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output sobel_pkg::out_t       out_data_o
);

  logic            push, pop, full, empty;
  sobel_pkg::win_t win_push, win_head;

  sobel_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .win_o      (win_push),
    .full_i     (full)
  );

  sobel_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (win_push),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (win_head)
  );

  sobel_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .win_i       (win_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
